// ===== sv/slt_pkg.sv =====
package slt_pkg;

    // Default table depth and fixed field widths
    localparam int SLT_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int OP_W         = 2;
    localparam int POS_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_slt_op;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BEYOND    = 2'd3
    } t_slt_status;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic               capture;
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] value;
    } t_slt_cmd;

endpackage

// ===== sv/slt_if.sv =====
interface slt_in_if import slt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface slt_out_if import slt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [ENTRY_COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

// ===== sv/slt_cell.sv =====
module slt_cell import slt_pkg::*; #(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 5
) (
    input  logic               i_clk,
    input  t_slt_cmd           i_cmd,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [VALUE_W-1:0] i_left_value,
    input  logic               i_left_gt,
    input  logic [VALUE_W-1:0] i_right_value,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_gt,
    output logic               o_ge
);

    localparam logic [COUNT_W-1:0] CELL_IDX = COUNT_W'(INDEX);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               r_gt;
    logic               r_ge;
    logic               w_valid;
    logic               w_tail;

    assign w_valid = CELL_IDX < i_count;
    assign w_tail  = CELL_IDX == i_count;

    // Capture the order of this entry against the request value
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gt <= w_valid && ($signed(r_entry) >  $signed(i_cmd.value));
            r_ge <= w_valid && ($signed(r_entry) >= $signed(i_cmd.value));
        end
    end

    // Shift right on insert, shift left on delete, else hold
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_left_gt) begin
                n_entry = i_left_value;
            end else if (r_gt || w_tail) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.del && r_ge) begin
            n_entry = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_value = r_entry;
    assign o_gt    = r_gt;
    assign o_ge    = r_ge;

endmodule

// ===== sv/sorted_list_table.sv =====
// Sorted table of signed 32-bit values, held in a row of cells.
// Input channel i_in carries one request item: operation (insert, delete
// first equal, clear, read), value and position. Output channel o_out
// returns exactly one result item per request: status, read_value (zero
// unless a read succeeds) and entry_count after the operation.
// Each item passes through accept, compare in every cell at once, and
// shift/commit, and the result is registered in the output register.
// A new item is accepted only in the idle state, after the previous one
// has committed, so the compare and shift steps never overlap two items.
// Equal values keep their order of arrival; delete removes the lowest one.
// Insert into a full table is refused with a full status.
// Reset empties the table and drops any pending result; entries past the
// count are never read, so the cell contents need no clearing.
// When the receiver stalls, the result waits in the output register; one
// further item may be accepted and compared, and it holds before commit
// until the output register drains.
module sorted_list_table import slt_pkg::*; #(
    parameter int CAPACITY = SLT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slt_in_if.sink    i_in,
    slt_out_if.source o_out
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int RD_N    = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int RD_W    = $clog2(RD_N);
    localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_slt_op              r_op;
    logic [VALUE_W-1:0]   r_value;
    logic [POS_W-1:0]     r_pos;

    logic                     r_out_valid, n_out_valid;
    t_slt_status              r_out_status, n_out_status;
    logic [VALUE_W-1:0]       r_out_read, n_out_read;
    logic [ENTRY_COUNT_W-1:0] r_out_count, n_out_count;

    t_slt_cmd             w_cmd;
    logic [VALUE_W-1:0]   w_val [CAPACITY];
    logic [VALUE_W-1:0]   w_rd  [RD_N];
    logic [CAPACITY-1:0]  w_gt;
    logic [CAPACITY-1:0]  w_ge;
    logic                 w_found;
    logic                 w_full;
    logic                 w_pos_ok;
    logic                 w_commit;
    logic                 w_accept;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_commit = (r_state == S_APPLY) && (!r_out_valid || o_out.ready);
    assign w_found  = |(w_ge & ~w_gt);
    assign w_full   = r_count >= COUNT_W'(CAPACITY);
    assign w_pos_ok = CMP_W'(r_pos) < CMP_W'(r_count);

    // Broadcast the request to the cell row
    always_comb begin
        w_cmd.capture = r_state == S_CMP;
        w_cmd.ins     = w_commit && (r_op == OP_INSERT) && !w_full;
        w_cmd.del     = w_commit && (r_op == OP_DELETE) && w_found;
        w_cmd.value   = r_value;
    end

    // Row of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left_value;
        logic               w_left_gt;
        logic [VALUE_W-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_gt    = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_val[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_value = w_val[g];
        end else begin : g_inner
            assign w_right_value = w_val[g+1];
        end

        slt_cell #(
            .INDEX   (g),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_count       (r_count),
            .i_left_value  (w_left_value),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .o_value       (w_val[g]),
            .o_gt          (w_gt[g]),
            .o_ge          (w_ge[g])
        );
    end

    // Readable window: the first positions only
    for (genvar k = 0; k < RD_N; k++) begin : g_rd
        assign w_rd[k] = w_val[k];
    end

    // Sequence the request and form the result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_read   = r_out_read;
        n_out_count  = r_out_count;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_commit) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_read   = '0;
                    case (r_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_found) begin
                                n_count = r_count - COUNT_W'(1);
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (w_pos_ok) begin
                                n_out_read = w_rd[r_pos[RD_W-1:0]];
                            end else begin
                                n_out_status = ST_BEYOND;
                            end
                        end
                        default: begin
                            n_out_status = ST_OK;
                        end
                    endcase
                    n_out_count = ENTRY_COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_slt_op'(i_in.operation);
            r_value <= i_in.value;
            r_pos   <= i_in.position;
        end
        r_out_status <= n_out_status;
        r_out_read   <= n_out_read;
        r_out_count  <= n_out_count;
    end

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.read_value  = r_out_read;
    assign o_out.entry_count = r_out_count;

endmodule

// ===== sv/slt_checker.sv =====
module slt_checker import slt_pkg::*; #(
    parameter int CAPACITY = SLT_CAPACITY
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [STATUS_W-1:0]      i_out_status,
    input logic [VALUE_W-1:0]       i_out_read_value,
    input logic [ENTRY_COUNT_W-1:0] i_out_entry_count
);

    // A stalled result item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_read_value) && $stable(i_out_entry_count))
        else $error("result item changed while stalled");

    // A result with a failure status carries a zero value
    a_zero_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> i_out_read_value == '0)
        else $error("non-zero read value on failed request");

    // A full refusal reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_FULL)
            |-> i_out_entry_count == ENTRY_COUNT_W'(CAPACITY))
        else $error("full status with table not full");

    // The count never exceeds the table depth (checked for depths below 32)
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CAPACITY >= 32) || (32'(i_out_entry_count) <= CAPACITY))
        else $error("entry count beyond capacity");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_list_table slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_read_value  (o_out.read_value),
    .i_out_entry_count (o_out.entry_count)
);
